// ----- rtl/core/rav_pkg.sv -----
// shared constants, types and operation codes for the rolling record averager
// used by the channel interfaces, the controller, the datapath and the top level
// no dependencies
package rav_pkg;

   localparam int REC_LEN   = 4096;
   localparam int IDX_W     = $clog2(REC_LEN);
   localparam int FILL_W    = IDX_W + 1;
   localparam int SRC_W     = IDX_W + 2;
   localparam int SAMPLE_W  = 64;
   localparam int SHOTS_W   = 48;
   localparam int SHIFT_W   = 13;
   localparam int OP_W      = 3;

   // rescale: product built 16 bits of the multiplier per step, then restoring divide
   localparam int CHUNK_W   = 16;
   localparam int MUL_STEPS = SHOTS_W / CHUNK_W;
   localparam int PP_W      = SAMPLE_W + CHUNK_W;
   localparam int PROD_W    = SAMPLE_W + SHOTS_W;
   localparam int DIV_STEPS = PROD_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_ADD_ONE  = 3'd0;
   localparam op_type OP_ADD_REC  = 3'd1;
   localparam op_type OP_SUB_REC  = 3'd2;
   localparam op_type OP_COPY_ONE = 3'd3;
   localparam op_type OP_ROLL     = 3'd4;

   typedef struct packed {
      logic load;
      logic calc;
      logic mul_step;
      logic div_step;
      logic sign;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic roll;
      logic out_free;
   } sts_type;

endpackage

// ----- rtl/core/rav_req_if.sv -----
// input item channel of the rolling record averager
// depends on rav_pkg
interface rav_req_if;
   import rav_pkg::*;

   logic                       valid;
   logic                       ready;
   op_type                     operation;
   logic signed [SAMPLE_W-1:0] incoming_sample;
   logic signed [SHIFT_W-1:0]  shift;
   logic [SHOTS_W-1:0]         incoming_shots;
   logic                       last;

   modport source (output valid, operation, incoming_sample, shift, incoming_shots, last,
                   input ready);
   modport sink   (input valid, operation, incoming_sample, shift, incoming_shots, last,
                   output ready);
endinterface

// ----- rtl/core/rav_rsp_if.sv -----
// result item channel of the rolling record averager
// depends on rav_pkg
interface rav_rsp_if;
   import rav_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [IDX_W-1:0]           position;
   logic signed [SAMPLE_W-1:0] accumulated;
   logic [SHOTS_W-1:0]         shot_count;
   logic                       record_done;

   modport source (output valid, position, accumulated, shot_count, record_done,
                   input ready);
   modport sink   (input valid, position, accumulated, shot_count, record_done,
                   output ready);
endinterface

// ----- rtl/core/rav_csr_if.sv -----
// configuration write channel of the rolling record averager (target_shots)
// depends on rav_pkg
interface rav_csr_if;
   import rav_pkg::*;

   logic               valid;
   logic               ready;
   logic [SHOTS_W-1:0] target_shots;

   modport source (output valid, target_shots, input ready);
   modport sink   (input valid, target_shots, output ready);
endinterface

// ----- rtl/core/rav_ctrl.sv -----
// controller of the rolling record averager: sequences load, update, rescale, commit
// depends on rav_pkg
module rav_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rav_pkg::sts_type sts,
   output rav_pkg::cmd_type cmd
);
   import rav_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CALC   = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_SIGN   = 3'd4;
   localparam logic [2:0] S_COMMIT = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
            if (in_valid) state_in = S_CALC;
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            cnt_in   = '0;
            state_in = sts.roll ? S_MUL : S_COMMIT;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == STEP_W'(MUL_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_DIV;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(DIV_STEPS - 1)) state_in = S_SIGN;
         end
         S_SIGN: begin
            cmd.sign = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            // hold until the output register can take the result
            cmd.commit = sts.out_free;
            if (sts.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- rtl/core/rav_dp.sv -----
// datapath of the rolling record averager: sum store, shot count, rescale unit,
// output register; depends on rav_pkg and the channel interfaces
module rav_dp (
   input  logic             clock,
   input  logic             reset,
   rav_req_if.sink          req_bus,
   rav_rsp_if.source        rsp_bus,
   rav_csr_if.sink          csr_bus,
   input  rav_pkg::cmd_type cmd,
   output rav_pkg::sts_type sts
);
   import rav_pkg::*;

   logic [SAMPLE_W-1:0]        sums_mem [REC_LEN];

   // item held while it is worked on
   op_type                     op_ff;
   logic [SAMPLE_W-1:0]        sample_ff;
   logic [SHIFT_W-1:0]         shift_ff;
   logic [SHOTS_W-1:0]         inshots_ff;
   logic                       last_ff;
   logic [IDX_W-1:0]           pos_ff;
   logic [SAMPLE_W-1:0]        rd_q_ff;
   logic                       rd_ok_ff;

   // block state
   logic [SHOTS_W-1:0]         target_shots_ff;
   logic [SHOTS_W-1:0]         shot_total_ff, shot_total_in;
   logic [IDX_W-1:0]           tidx_ff, tidx_in;
   logic [FILL_W-1:0]          fill_ff;

   // update and rescale
   logic [SAMPLE_W-1:0]        res_sum_ff, res_sum_in;
   logic [SHOTS_W-1:0]         newshots_ff, newshots_in;
   logic [SAMPLE_W-1:0]        mag_ff;
   logic                       neg_ff;
   logic [SHOTS_W-1:0]         t_ff;
   logic [SHOTS_W:0]           d_ff;
   logic [PROD_W-1:0]          acc_ff, acc_in;
   logic [SHOTS_W:0]           rem_ff, rem_in;

   // output register
   logic                       rsp_valid_ff;
   logic [IDX_W-1:0]           rsp_pos_ff;
   logic [SAMPLE_W-1:0]        rsp_sum_ff;
   logic [SHOTS_W-1:0]         rsp_shots_ff;
   logic                       rsp_done_ff;

   logic [SAMPLE_W-1:0]        cur, sum_add, sum_sub, base;
   logic [SRC_W-1:0]           src;
   logic                       ok;
   logic [SHOTS_W:0]           total, inc_one, inc_in;
   logic [SHOTS_W-1:0]         sat_one, sat_in, sat_sub;
   logic [PP_W-1:0]            pp;
   logic [SHOTS_W+1:0]         trial;
   logic                       ge;

   assign csr_bus.ready = 1'b1;

   // element alignment and candidate sums
   always_comb begin
      cur     = rd_ok_ff ? rd_q_ff : '0;
      src     = {2'b00, pos_ff} + {shift_ff[SHIFT_W-1], shift_ff};
      ok      = (src[SRC_W-1:IDX_W] == 2'b00);
      sum_add = cur + sample_ff;
      sum_sub = cur - sample_ff;
      base    = ok ? sum_add : cur;
      total   = {1'b0, shot_total_ff} + {1'b0, inshots_ff};
      inc_one = {1'b0, shot_total_ff} + (SHOTS_W + 1)'(1);
      inc_in  = total;
      sat_one = inc_one[SHOTS_W] ? '1 : inc_one[SHOTS_W-1:0];
      sat_in  = inc_in[SHOTS_W] ? '1 : inc_in[SHOTS_W-1:0];
      sat_sub = (inshots_ff > shot_total_ff) ? '0 : shot_total_ff - inshots_ff;
      sts.roll = (op_ff == OP_ROLL) && (total > {1'b0, target_shots_ff});
      sts.out_free = !rsp_valid_ff || rsp_bus.ready;
   end

   always_comb begin
      res_sum_in  = cur;
      newshots_in = shot_total_ff;
      unique case (op_ff)
         OP_ADD_ONE: begin
            res_sum_in  = base;
            newshots_in = sat_one;
         end
         OP_ADD_REC: begin
            res_sum_in  = base;
            newshots_in = sat_in;
         end
         OP_SUB_REC: begin
            res_sum_in  = ok ? sum_sub : cur;
            newshots_in = sat_sub;
         end
         OP_COPY_ONE: begin
            res_sum_in  = ok ? sample_ff : cur;
            newshots_in = sat_one;
         end
         OP_ROLL: begin
            res_sum_in  = base;
            newshots_in = sts.roll ? target_shots_ff : sat_in;
         end
         default: begin
            res_sum_in  = cur;
            newshots_in = shot_total_ff;
         end
      endcase
   end

   // rescale: shift-add multiply by 16-bit chunks, then restoring divide in place
   always_comb begin
      pp     = {{CHUNK_W{1'b0}}, mag_ff}
             * {{SAMPLE_W{1'b0}}, t_ff[SHOTS_W-1 -: CHUNK_W]};
      trial  = {rem_ff, acc_ff[PROD_W-1]};
      ge     = trial >= {1'b0, d_ff};
      acc_in = acc_ff;
      rem_in = rem_ff;
      if (cmd.mul_step) begin
         acc_in = {acc_ff[PROD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}}
                + {{(PROD_W - PP_W){1'b0}}, pp};
      end else if (cmd.div_step) begin
         rem_in = ge ? (SHOTS_W + 1)'(trial - {1'b0, d_ff}) : trial[SHOTS_W:0];
         acc_in = {acc_ff[PROD_W-2:0], ge};
      end
   end

   always_comb begin
      shot_total_in = last_ff ? newshots_ff : shot_total_ff;
      if (last_ff || pos_ff == IDX_W'(REC_LEN - 1)) tidx_in = '0;
      else tidx_in = pos_ff + IDX_W'(1);
   end

   // sum store: registered read on accept, write on commit
   always_ff @(posedge clock) begin
      if (cmd.load) rd_q_ff <= sums_mem[tidx_ff];
      if (cmd.commit) sums_mem[pos_ff] <= res_sum_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_bus.operation;
         sample_ff  <= req_bus.incoming_sample;
         shift_ff   <= req_bus.shift;
         inshots_ff <= req_bus.incoming_shots;
         last_ff    <= req_bus.last;
         pos_ff     <= tidx_ff;
         // entries at or past the fill mark were never written and read as zero
         rd_ok_ff   <= {1'b0, tidx_ff} < fill_ff;
      end
      if (cmd.calc) begin
         res_sum_ff  <= res_sum_in;
         newshots_ff <= newshots_in;
         neg_ff      <= base[SAMPLE_W-1];
         mag_ff      <= base[SAMPLE_W-1] ? -base : base;
         d_ff        <= total;
         acc_ff      <= '0;
         rem_ff      <= '0;
      end else begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
      end
      if (cmd.calc) t_ff <= target_shots_ff;
      else if (cmd.mul_step) t_ff <= t_ff << CHUNK_W;
      if (cmd.sign) begin
         res_sum_ff <= neg_ff ? -acc_ff[SAMPLE_W-1:0] : acc_ff[SAMPLE_W-1:0];
      end
      if (cmd.commit) begin
         rsp_pos_ff   <= pos_ff;
         rsp_sum_ff   <= res_sum_ff;
         rsp_shots_ff <= shot_total_in;
         rsp_done_ff  <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_shots_ff <= '1;
         shot_total_ff   <= '0;
         tidx_ff         <= '0;
         fill_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_bus.valid) target_shots_ff <= csr_bus.target_shots;
         if (cmd.commit) begin
            shot_total_ff <= shot_total_in;
            tidx_ff       <= tidx_in;
            // writes run upward from zero, so the written entries form a prefix
            if ({1'b0, pos_ff} == fill_ff) fill_ff <= fill_ff + FILL_W'(1);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.position    = rsp_pos_ff;
   assign rsp_bus.accumulated = rsp_sum_ff;
   assign rsp_bus.shot_count  = rsp_shots_ff;
   assign rsp_bus.record_done = rsp_done_ff;

endmodule

// ----- rtl/core/record_averager_rolling.sv -----
// Rolling record averager: keeps 4096 wrapping 64-bit sums and a saturating 48-bit
// shot count, one item per target position in order. Items are taken one at a time.
// Add, subtract and copy operations, and a rolling average that stays at or under
// target_shots, go through accept, update and commit to the output register.
// A rolling average that must rescale builds the product target*sum in 16-bit
// chunks with a 64x16 multiplier and divides it by the combined shot count with a
// one-bit-per-cycle restoring divider. A result waiting in the output register does
// not stop the next item from being accepted, only from being committed. The sum
// store needs no clearing after reset: entries not yet written since reset read as
// zero through a fill mark. target_shots may be written while idle.
// depends on rav_pkg, the channel interfaces, rav_ctrl and rav_dp
module record_averager_rolling (
   input  logic      clock,
   input  logic      reset,
   rav_req_if.sink   req_bus,
   rav_rsp_if.source rsp_bus,
   rav_csr_if.sink   csr_bus
);
   import rav_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    in_ready;

   assign req_bus.ready = in_ready;

   rav_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_ready (in_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   rav_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .cmd     (cmd),
      .sts     (sts)
   );

   // at most one step of the sequence is active in a cycle
   a_one_cmd : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.calc, cmd.mul_step, cmd.div_step, cmd.sign, cmd.commit}))
      else $error("more than one datapath command active");

   // a commit always leaves a result in the output register
   a_commit_rsp : assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_bus.valid)
      else $error("commit did not present a result");

   // one item at a time: no accept right after an accept
   a_one_item : assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("input accepted while an item is in progress");

   // a load is never followed directly by a commit
   a_commit_load : assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !cmd.commit)
      else $error("commit in the cycle after load");

endmodule
